// File: src/hcrm_pkg.sv
// Package of the Hall current RMS meter: field widths, reset values,
// action and result codes, and the sequencer state encoding.
// No dependencies; the top level refers to it by scoped names.
package hcrm_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CURRENT_W  = 23;
  localparam int unsigned CAL_SUM_W  = 14;
  localparam int unsigned CAL_CNT_W  = 4;
  localparam int unsigned SQ_SUM_W   = 40;
  localparam int unsigned ROOT_W     = 24;
  localparam int unsigned MUL_B_W    = 16;
  localparam int unsigned MUL_DIGIT_W = 4;

  // Parameter defaults.
  localparam int unsigned ADC_BITS_DEFAULT    = 10;
  localparam int unsigned CAL_SAMPLES_DEFAULT = 10;
  localparam int unsigned MAX_WINDOW_DEFAULT  = 65536;

  // Reset values and limits.
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd5867;
  localparam logic [SAMPLE_W-1:0]  ZERO_RESET = 10'd512;
  localparam logic [CURRENT_W-1:0] CUR_MAX    = 23'h3F_FFFF;

  // Register map: index of each configuration register.
  localparam logic [0:0] REG_CURRENT_GAIN = 1'b0;

  typedef enum logic [1:0] {
    ACT_CAL      = 2'd0,
    ACT_SET_ZERO = 2'd1,
    ACT_DC       = 2'd2,
    ACT_RMS      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_DC   = 2'd0,
    KIND_RMS  = 2'd1,
    KIND_ZERO = 2'd2
  } kind_e;

  // What the shared multiplier or divider is currently working for.
  typedef enum logic [1:0] {
    JOB_CAL = 2'd0,
    JOB_DC  = 2'd1,
    JOB_SQ  = 2'd2,
    JOB_RMS = 2'd3
  } job_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_FIN  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

// File: src/hall_current_rms_meter.sv
// Hall current RMS meter top level: sample stream in, current stream out,
// APB register for the gain. Depends on hcrm_pkg.
//
// Each item carries one converter sample and an action. Calibrate items are
// summed, and every CAL_SAMPLES of them load their truncated mean as the zero
// point; set-zero items load the zero point directly; DC items answer the
// signed offset times the gain; RMS items add up squared offsets until the
// item marked last, which answers the root of the mean square times the gain.
// Items are taken one at a time: s_axis_tready is high only while the
// sequencer is idle, and a finished result waits in the output register
// without holding up the next item. All arithmetic runs on one shared
// datapath that is narrow by construction: a multiplier that consumes four
// bits of its second operand per cycle, a restoring divider that produces
// one quotient bit per cycle, and a square root that retires two radicand
// bits per cycle. A calibrate item that does not complete the set is only
// summed; a completing one runs 40 divide steps. A set-zero item goes
// straight to the output state, a DC item runs four multiply steps, and an
// RMS item that does not close the window four multiply steps and the
// accumulate. The closing RMS item runs the squaring, 40 divide steps for
// the mean, 24 root steps and four multiply steps by the gain.
module hall_current_rms_meter #(
  parameter int unsigned ADC_BITS    = hcrm_pkg::ADC_BITS_DEFAULT,
  parameter int unsigned CAL_SAMPLES = hcrm_pkg::CAL_SAMPLES_DEFAULT,
  parameter int unsigned MAX_WINDOW  = hcrm_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] sample_value
  input  logic        s_axis_tlast,   // last_in_window
  input  logic [1:0]  s_axis_tuser,   // [1:0] action

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [22:0] current_ma, [32:23] zero_value
  output logic [2:0]  m_axis_tuser,   // [1:0] result_kind, [2] saturated

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SampleW  = hcrm_pkg::SAMPLE_W;
  localparam int unsigned GainW    = hcrm_pkg::GAIN_W;
  localparam int unsigned CurW     = hcrm_pkg::CURRENT_W;
  localparam int unsigned CalSumW  = hcrm_pkg::CAL_SUM_W;
  localparam int unsigned CalCntW  = hcrm_pkg::CAL_CNT_W;
  localparam int unsigned SqSumW   = hcrm_pkg::SQ_SUM_W;
  localparam int unsigned RootW    = hcrm_pkg::ROOT_W;
  localparam int unsigned RadW     = 2 * RootW;
  localparam int unsigned SqRemW   = RootW + 2;
  localparam int unsigned MulW     = SqSumW;
  localparam int unsigned MulBW    = hcrm_pkg::MUL_B_W;
  localparam int unsigned DigitW   = hcrm_pkg::MUL_DIGIT_W;
  localparam int unsigned MulSteps = MulBW / DigitW;
  localparam int unsigned MulCntW  = $clog2(MulSteps);
  localparam int unsigned DivCntW  = $clog2(SqSumW);
  localparam int unsigned SqCntW   = $clog2(RootW);
  localparam int unsigned WinW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DivW     = (WinW > CalCntW) ? WinW : CalCntW;
  localparam int unsigned ReadBits = (ADC_BITS < SampleW) ? ADC_BITS : SampleW;
  localparam logic [SampleW-1:0] ReadMask = SampleW'((32'd1 << ReadBits) - 32'd1);
  localparam logic [WinW-1:0]    MaxWin   = WinW'(MAX_WINDOW);
  localparam logic [CalCntW-1:0] CalLast  = CalCntW'(CAL_SAMPLES - 1);

  hcrm_pkg::state_e state_q, state_d;
  hcrm_pkg::job_e   job_q, job_d;

  logic [GainW-1:0]   gain_q;
  logic [SampleW-1:0] zero_q, zero_d;
  logic [CalSumW-1:0] cal_sum_q, cal_sum_d;
  logic [CalCntW-1:0] cal_cnt_q, cal_cnt_d;
  logic [SqSumW-1:0]  sq_sum_q, sq_sum_d;
  logic [WinW-1:0]    win_cnt_q, win_cnt_d;
  logic               ovf_q, ovf_d;
  logic               neg_q, neg_d;
  logic               last_q, last_d;

  // Multiplier.
  logic [MulW-1:0]    mul_a_q, mul_a_d;
  logic [MulBW-1:0]   mul_b_q, mul_b_d;
  logic [MulW-1:0]    mul_p_q, mul_p_d;
  logic [MulCntW-1:0] mul_cnt_q, mul_cnt_d;
  logic [MulW+DigitW-1:0] mul_prod;
  logic [MulW-1:0]    mul_p_nx;

  // Divider.
  logic [SqSumW-1:0]  div_n_q, div_n_d;
  logic [DivW-1:0]    div_r_q, div_r_d;
  logic [DivW-1:0]    div_v_q, div_v_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [DivW:0]      div_t;
  logic               div_ge;
  logic [SqSumW-1:0]  div_n_nx;
  logic [DivW-1:0]    div_r_nx;

  // Square root.
  logic [RadW-1:0]    sq_v_q, sq_v_d;
  logic [RootW-1:0]   sq_root_q, sq_root_d;
  logic [SqRemW-1:0]  sq_rem_q, sq_rem_d;
  logic [SqCntW-1:0]  sq_cnt_q, sq_cnt_d;
  logic [SqRemW+1:0]  sq_t;
  logic [SqRemW+1:0]  sq_trial;
  logic               sq_ge;
  logic [RootW-1:0]   sq_root_nx;
  logic [SqRemW-1:0]  sq_rem_nx;

  // Pending result and output register.
  hcrm_pkg::kind_e    res_kind_q, res_kind_d;
  logic [CurW-1:0]    res_cur_q, res_cur_d;
  logic               res_sat_q, res_sat_d;
  logic               m_valid_q, m_valid_d;
  logic [39:0]        m_data_q, m_data_d;
  logic [2:0]         m_user_q, m_user_d;

  // Input decode.
  logic               in_hs;
  hcrm_pkg::action_e  in_act;
  logic [SampleW-1:0] in_smp;
  logic [SampleW:0]   in_diff;
  logic [SampleW:0]   in_mag_full;
  logic [SampleW-1:0] in_mag;
  logic [CalSumW:0]   cal_sum_ext;
  logic [CalSumW-1:0] cal_sum_sat;
  logic [SqSumW:0]    sq_sum_ext;
  logic [SqSumW-1:0]  sq_sum_nx;
  logic [CurW-1:0]    dc_mag;
  logic [31:0]        rms_m;
  logic               cfg_wr;

  assign s_axis_tready = (state_q == hcrm_pkg::ST_IDLE);
  assign in_hs   = s_axis_tvalid && s_axis_tready;
  assign in_act  = hcrm_pkg::action_e'(s_axis_tuser);
  assign in_smp  = s_axis_tdata[SampleW-1:0] & ReadMask;
  assign in_diff = {1'b0, zero_q} - {1'b0, in_smp};
  assign in_mag_full = in_diff[SampleW] ? (~in_diff + 1'b1) : in_diff;
  assign in_mag  = in_mag_full[SampleW-1:0];

  assign cal_sum_ext = {1'b0, cal_sum_q} + (CalSumW + 1)'(in_smp);
  assign cal_sum_sat = cal_sum_ext[CalSumW] ? '1 : cal_sum_ext[CalSumW-1:0];

  // One multiplier digit per cycle: the low digit of b times the shifted a.
  assign mul_prod = mul_a_q * mul_b_q[DigitW-1:0];
  assign mul_p_nx = mul_p_q + mul_prod[MulW-1:0];

  // Restoring division, one quotient bit per cycle. The quotient shifts into
  // the dividend register as the dividend bits shift out.
  assign div_t    = {div_r_q, div_n_q[SqSumW-1]};
  assign div_ge   = (div_t >= {1'b0, div_v_q});
  assign div_r_nx = div_ge ? DivW'(div_t - {1'b0, div_v_q}) : div_t[DivW-1:0];
  assign div_n_nx = {div_n_q[SqSumW-2:0], div_ge};

  // Digit-by-digit square root on two radicand bits per cycle.
  assign sq_t       = {sq_rem_q, sq_v_q[RadW-1 -: 2]};
  assign sq_trial   = {2'b00, sq_root_q, 2'b01};
  assign sq_ge      = (sq_t >= sq_trial);
  assign sq_rem_nx  = sq_ge ? SqRemW'(sq_t - sq_trial) : sq_t[SqRemW-1:0];
  assign sq_root_nx = {sq_root_q[RootW-2:0], sq_ge};

  assign sq_sum_ext = {1'b0, sq_sum_q} + {1'b0, mul_p_q};
  assign sq_sum_nx  = sq_sum_ext[SqSumW] ? '1 : sq_sum_ext[SqSumW-1:0];

  assign dc_mag = mul_p_q[CurW+3:4];
  assign rms_m  = mul_p_q[MulW-1:8];

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    zero_d     = zero_q;
    cal_sum_d  = cal_sum_q;
    cal_cnt_d  = cal_cnt_q;
    sq_sum_d   = sq_sum_q;
    win_cnt_d  = win_cnt_q;
    ovf_d      = ovf_q;
    neg_d      = neg_q;
    last_d     = last_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    mul_p_d    = mul_p_q;
    mul_cnt_d  = mul_cnt_q;
    div_n_d    = div_n_q;
    div_r_d    = div_r_q;
    div_v_d    = div_v_q;
    div_cnt_d  = div_cnt_q;
    sq_v_d     = sq_v_q;
    sq_root_d  = sq_root_q;
    sq_rem_d   = sq_rem_q;
    sq_cnt_d   = sq_cnt_q;
    res_kind_d = res_kind_q;
    res_cur_d  = res_cur_q;
    res_sat_d  = res_sat_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;

    unique case (state_q)
      hcrm_pkg::ST_IDLE: begin
        if (in_hs) begin
          neg_d  = in_diff[SampleW];
          last_d = s_axis_tlast;
          unique case (in_act)
            hcrm_pkg::ACT_CAL: begin
              if (cal_cnt_q == CalLast) begin
                div_n_d   = SqSumW'(cal_sum_sat);
                div_v_d   = DivW'(CAL_SAMPLES);
                div_r_d   = '0;
                div_cnt_d = '0;
                job_d     = hcrm_pkg::JOB_CAL;
                cal_sum_d = '0;
                cal_cnt_d = '0;
                state_d   = hcrm_pkg::ST_DIV;
              end else begin
                cal_sum_d = cal_sum_sat;
                cal_cnt_d = cal_cnt_q + 1'b1;
              end
            end
            hcrm_pkg::ACT_SET_ZERO: begin
              zero_d     = s_axis_tdata[SampleW-1:0];
              res_kind_d = hcrm_pkg::KIND_ZERO;
              res_cur_d  = '0;
              res_sat_d  = 1'b0;
              state_d    = hcrm_pkg::ST_OUT;
            end
            hcrm_pkg::ACT_DC: begin
              mul_a_d   = MulW'(in_mag);
              mul_b_d   = gain_q;
              mul_p_d   = '0;
              mul_cnt_d = '0;
              job_d     = hcrm_pkg::JOB_DC;
              state_d   = hcrm_pkg::ST_MUL;
            end
            hcrm_pkg::ACT_RMS: begin
              if (win_cnt_q >= MaxWin) begin
                // Window full: the sample is dropped and flagged.
                ovf_d = 1'b1;
                if (s_axis_tlast) begin
                  div_n_d   = sq_sum_q;
                  div_v_d   = DivW'(win_cnt_q);
                  div_r_d   = '0;
                  div_cnt_d = '0;
                  job_d     = hcrm_pkg::JOB_RMS;
                  state_d   = hcrm_pkg::ST_DIV;
                end
              end else begin
                mul_a_d   = MulW'(in_mag);
                mul_b_d   = MulBW'(in_mag);
                mul_p_d   = '0;
                mul_cnt_d = '0;
                job_d     = hcrm_pkg::JOB_SQ;
                state_d   = hcrm_pkg::ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end

      hcrm_pkg::ST_MUL: begin
        mul_p_d   = mul_p_nx;
        mul_a_d   = {mul_a_q[MulW-DigitW-1:0], {DigitW{1'b0}}};
        mul_b_d   = {{DigitW{1'b0}}, mul_b_q[MulBW-1:DigitW]};
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == MulCntW'(MulSteps - 1)) begin
          state_d = hcrm_pkg::ST_FIN;
        end
      end

      hcrm_pkg::ST_FIN: begin
        case (job_q)
          hcrm_pkg::JOB_DC: begin
            res_kind_d = hcrm_pkg::KIND_DC;
            res_cur_d  = neg_q ? (~dc_mag + 1'b1) : dc_mag;
            res_sat_d  = 1'b0;
            state_d    = hcrm_pkg::ST_OUT;
          end
          hcrm_pkg::JOB_SQ: begin
            sq_sum_d  = sq_sum_nx;
            win_cnt_d = win_cnt_q + 1'b1;
            if (sq_sum_ext[SqSumW]) begin
              ovf_d = 1'b1;
            end
            if (last_q) begin
              div_n_d   = sq_sum_nx;
              div_v_d   = DivW'(win_cnt_q + 1'b1);
              div_r_d   = '0;
              div_cnt_d = '0;
              job_d     = hcrm_pkg::JOB_RMS;
              state_d   = hcrm_pkg::ST_DIV;
            end else begin
              state_d = hcrm_pkg::ST_IDLE;
            end
          end
          hcrm_pkg::JOB_RMS: begin
            res_kind_d = hcrm_pkg::KIND_RMS;
            res_cur_d  = (rms_m > 32'(hcrm_pkg::CUR_MAX)) ? hcrm_pkg::CUR_MAX
                                                          : rms_m[CurW-1:0];
            res_sat_d  = ovf_q;
            sq_sum_d   = '0;
            win_cnt_d  = '0;
            ovf_d      = 1'b0;
            state_d    = hcrm_pkg::ST_OUT;
          end
          default: state_d = hcrm_pkg::ST_IDLE;
        endcase
      end

      hcrm_pkg::ST_DIV: begin
        div_n_d   = div_n_nx;
        div_r_d   = div_r_nx;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(SqSumW - 1)) begin
          if (job_q == hcrm_pkg::JOB_CAL) begin
            zero_d     = (|div_n_nx[SqSumW-1:SampleW]) ? '1 : div_n_nx[SampleW-1:0];
            res_kind_d = hcrm_pkg::KIND_ZERO;
            res_cur_d  = '0;
            res_sat_d  = 1'b0;
            state_d    = hcrm_pkg::ST_OUT;
          end else begin
            // The root is taken of mean * 256 to get four fractional bits.
            sq_v_d    = {div_n_nx, 8'h00};
            sq_root_d = '0;
            sq_rem_d  = '0;
            sq_cnt_d  = '0;
            state_d   = hcrm_pkg::ST_SQRT;
          end
        end
      end

      hcrm_pkg::ST_SQRT: begin
        sq_v_d    = {sq_v_q[RadW-3:0], 2'b00};
        sq_root_d = sq_root_nx;
        sq_rem_d  = sq_rem_nx;
        sq_cnt_d  = sq_cnt_q + 1'b1;
        if (sq_cnt_q == SqCntW'(RootW - 1)) begin
          mul_a_d   = MulW'(sq_root_nx);
          mul_b_d   = gain_q;
          mul_p_d   = '0;
          mul_cnt_d = '0;
          state_d   = hcrm_pkg::ST_MUL;
        end
      end

      hcrm_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'b0, zero_q, res_cur_q};
          m_user_d  = {res_sat_q, res_kind_q};
          state_d   = hcrm_pkg::ST_IDLE;
        end
      end

      default: state_d = hcrm_pkg::ST_IDLE;
    endcase
  end

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hcrm_pkg::REG_CURRENT_GAIN);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hcrm_pkg::REG_CURRENT_GAIN) ? {16'h0000, gain_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hcrm_pkg::ST_IDLE;
      job_q     <= hcrm_pkg::JOB_CAL;
      gain_q    <= hcrm_pkg::GAIN_RESET;
      zero_q    <= hcrm_pkg::ZERO_RESET;
      cal_sum_q <= '0;
      cal_cnt_q <= '0;
      sq_sum_q  <= '0;
      win_cnt_q <= '0;
      ovf_q     <= 1'b0;
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
      sq_cnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      if (cfg_wr) begin
        gain_q <= pwdata[GainW-1:0];
      end
      zero_q    <= zero_d;
      cal_sum_q <= cal_sum_d;
      cal_cnt_q <= cal_cnt_d;
      sq_sum_q  <= sq_sum_d;
      win_cnt_q <= win_cnt_d;
      ovf_q     <= ovf_d;
      mul_cnt_q <= mul_cnt_d;
      div_cnt_q <= div_cnt_d;
      sq_cnt_q  <= sq_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    last_q     <= last_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    mul_p_q    <= mul_p_d;
    div_n_q    <= div_n_d;
    div_r_q    <= div_r_d;
    div_v_q    <= div_v_d;
    sq_v_q     <= sq_v_d;
    sq_root_q  <= sq_root_d;
    sq_rem_q   <= sq_rem_d;
    res_kind_q <= res_kind_d;
    res_cur_q  <= res_cur_d;
    res_sat_q  <= res_sat_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The divisor is a window count or the calibration size, never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcrm_pkg::ST_DIV) |-> (div_v_q != '0))
    else $error("divider running with a zero divisor");

  // A restoring step must leave a partial remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcrm_pkg::ST_DIV) && (div_cnt_q != '0) |-> (div_r_q < div_v_q))
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cnt_q <= MaxWin)
    else $error("window count beyond the window limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_cnt_q <= CalLast)
    else $error("calibration count reached the set size without closing");

  // A finished result moves into a free output slot; the sequencer goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcrm_pkg::ST_OUT) && (!m_valid_q || m_axis_tready) |=>
      m_valid_q && (state_q == hcrm_pkg::ST_IDLE))
    else $error("finished result not moved into the output register");

endmodule
